>>> sv/sme_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the stack machine execute unit.
package sme_pkg;

    localparam int DATA_W      = 32;
    localparam int CMD_W       = 4;
    localparam int VIX_W       = 6;
    localparam int STATUS_W    = 3;
    localparam int DEPTH_OUT_W = 7;
    // Number of variable slots that the index field can reach.
    localparam int VAR_LIMIT   = 1 << VIX_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH     = 4'd0,
        CMD_POP      = 4'd1,
        CMD_SETLOCAL = 4'd2,
        CMD_GETLOCAL = 4'd3,
        CMD_ADD      = 4'd4,
        CMD_SUB      = 4'd5,
        CMD_MUL      = 4'd6,
        CMD_DIV      = 4'd7,
        CMD_PRINT    = 4'd8
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK         = 3'd0,
        STS_UNDERFLOW  = 3'd1,
        STS_OVERFLOW   = 3'd2,
        STS_DIV_ZERO   = 3'd3,
        STS_UNDECLARED = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_LOAD,
        FSM_EXEC,
        FSM_DIV,
        FSM_DONE
    } fsm_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

endpackage

>>> sv/sme_ram.sv
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM with a registered read port.
module sme_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 32
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/sme_div.sv
`timescale 1ns / 1ps
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module sme_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  sme_pkg::div_req_t req,
    output sme_pkg::div_rsp_t rsp
);

    localparam int DW = sme_pkg::DATA_W;
    localparam int CNTW = $clog2(DW);
    localparam logic [CNTW-1:0] LAST_STEP = CNTW'(DW - 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] step_reg, step_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [DW-1:0]   dmag_reg, dmag_next;
    logic            neg_reg, neg_next;

    logic [DW:0]     rem_shift;
    logic [DW:0]     diff;
    logic            num_neg, den_neg;

    always_comb begin
        num_neg   = req.dividend[DW-1];
        den_neg   = req.divisor[DW-1];
        rem_shift = {rem_reg, quo_reg[DW-1]};
        diff      = rem_shift - {1'b0, dmag_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;

        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = num_neg ? (DW'(0) - req.dividend) : req.dividend;
            dmag_next = den_neg ? (DW'(0) - req.divisor) : req.divisor;
            neg_next  = num_neg ^ den_neg;
        end else if (busy_reg) begin
            // Restoring step: keep the trial difference when it did not go negative.
            if (!diff[DW]) begin
                rem_next = diff[DW-1:0];
            end else begin
                rem_next = rem_shift[DW-1:0];
            end
            quo_next  = {quo_reg[DW-2:0], ~diff[DW]};
            step_next = step_reg + CNTW'(1);
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (DW'(0) - quo_reg) : quo_reg;

endmodule

>>> sv/stack_machine_execute_unit.sv
`timescale 1ns / 1ps
// Stack machine execute unit: sequencer, stack and variable memories, divider.
//
// Each request on the s_ channel is one decoded instruction (s_tuser holds the
// command, s_tdata the immediate and the variable number). For each request
// exactly one result leaves on the m_ channel with a status, the printed value
// and the stack depth after the instruction.
// The top of the stack sits in a register; the entries below it live in a
// one-port-read RAM, and the variables in a second RAM with valid flags.
// Path from request to result: push, setlocal, print and any error go from idle
// straight to the done state; pop and getlocal pass a load state, and add, sub
// and mul an exec state, where the RAM read of the entry below the top or of
// the variable is awaited; div passes the exec state and then waits in a
// divide state for the 32-step divider. A new request is taken once the
// previous result has been placed in the output register, not before.
// Reset empties the stack and clears all variable valid flags; no clearing
// pass is needed. When the receiver stalls, the finished result waits in the
// output register and the block still takes and works on the next request;
// that one then waits for the output register to drain.
module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int NUM_VARS    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] immediate, [37:32] var_index, rest zero
    input  logic [3:0]  s_tuser,   // [3:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] print_value, [38:32] stack_depth, rest zero
    output logic [3:0]  m_tuser    // [2:0] status, [3] print_valid
);

    localparam int DW  = sme_pkg::DATA_W;
    localparam int CW  = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int VAR_SLOTS = (NUM_VARS < sme_pkg::VAR_LIMIT) ? NUM_VARS
                                                                : sme_pkg::VAR_LIMIT;
    localparam int VAW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;
    localparam logic [CW-1:0] DEPTH_FULL = CW'(STACK_DEPTH);

    sme_pkg::fsm_t state_reg, state_next;

    logic [CW-1:0]                  count_reg, count_next;
    logic [DW-1:0]                  top_reg, top_next;
    logic [sme_pkg::CMD_W-1:0]      cmd_reg, cmd_next;
    sme_pkg::status_t               status_reg, status_next;
    logic [VAR_SLOTS-1:0]           declared_reg, declared_next;

    logic                           m_valid_reg, m_valid_next;
    sme_pkg::status_t               o_status_reg, o_status_next;
    logic                           o_pvalid_reg, o_pvalid_next;
    logic [DW-1:0]                  o_pvalue_reg, o_pvalue_next;
    logic [sme_pkg::DEPTH_OUT_W-1:0] o_depth_reg, o_depth_next;

    logic [sme_pkg::CMD_W-1:0]      in_cmd;
    logic [DW-1:0]                  in_imm;
    logic [sme_pkg::VIX_W-1:0]      in_vix;
    logic [VAW-1:0]                 var_addr;
    logic                           var_in_range;
    logic                           var_declared;
    logic                           stk_full, stk_empty, stk_short;
    sme_pkg::status_t               acc_status;
    logic [CW-1:0]                  count_m1, count_m2;
    logic                           out_free;

    logic                           stk_we, stk_re;
    logic [SAW-1:0]                 stk_waddr, stk_raddr;
    logic [DW-1:0]                  stk_wdata, stk_rdata;
    logic                           var_we, var_re;
    logic [DW-1:0]                  var_rdata;

    sme_pkg::div_req_t              div_req;
    sme_pkg::div_rsp_t              div_rsp;

    assign in_cmd   = s_tuser[3:0];
    assign in_imm   = s_tdata[31:0];
    assign in_vix   = s_tdata[37:32];
    assign var_addr = VAW'(in_vix);

    assign count_m1 = count_reg - CW'(1);
    assign count_m2 = count_reg - CW'(2);

    assign s_tready = (state_reg == sme_pkg::FSM_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // Status of the incoming request, decided from the state before it runs.
    always_comb begin
        stk_full     = (count_reg == DEPTH_FULL);
        stk_empty    = (count_reg == '0);
        stk_short    = (count_reg < CW'(2));
        var_in_range = (32'(in_vix) < 32'(NUM_VARS));
        var_declared = var_in_range && declared_reg[var_addr];
        acc_status   = sme_pkg::STS_OK;
        case (in_cmd)
            sme_pkg::CMD_PUSH: begin
                if (stk_full) acc_status = sme_pkg::STS_OVERFLOW;
            end
            sme_pkg::CMD_POP, sme_pkg::CMD_PRINT: begin
                if (stk_empty) acc_status = sme_pkg::STS_UNDERFLOW;
            end
            sme_pkg::CMD_SETLOCAL: begin
                if (stk_empty) begin
                    acc_status = sme_pkg::STS_UNDERFLOW;
                end else if (!var_in_range) begin
                    acc_status = sme_pkg::STS_UNDECLARED;
                end
            end
            sme_pkg::CMD_GETLOCAL: begin
                if (!var_declared) begin
                    acc_status = sme_pkg::STS_UNDECLARED;
                end else if (stk_full) begin
                    acc_status = sme_pkg::STS_OVERFLOW;
                end
            end
            sme_pkg::CMD_ADD, sme_pkg::CMD_SUB, sme_pkg::CMD_MUL: begin
                if (stk_short) acc_status = sme_pkg::STS_UNDERFLOW;
            end
            sme_pkg::CMD_DIV: begin
                if (stk_short) begin
                    acc_status = sme_pkg::STS_UNDERFLOW;
                end else if (top_reg == '0) begin
                    acc_status = sme_pkg::STS_DIV_ZERO;
                end
            end
            default: acc_status = sme_pkg::STS_OK;
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sme_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    if (acc_status != sme_pkg::STS_OK) begin
                        state_next = sme_pkg::FSM_DONE;
                    end else begin
                        case (in_cmd)
                            sme_pkg::CMD_POP, sme_pkg::CMD_GETLOCAL:
                                state_next = sme_pkg::FSM_LOAD;
                            sme_pkg::CMD_ADD, sme_pkg::CMD_SUB,
                            sme_pkg::CMD_MUL, sme_pkg::CMD_DIV:
                                state_next = sme_pkg::FSM_EXEC;
                            default:
                                state_next = sme_pkg::FSM_DONE;
                        endcase
                    end
                end
            end
            sme_pkg::FSM_LOAD: state_next = sme_pkg::FSM_DONE;
            sme_pkg::FSM_EXEC: begin
                if (cmd_reg == sme_pkg::CMD_DIV) begin
                    state_next = sme_pkg::FSM_DIV;
                end else begin
                    state_next = sme_pkg::FSM_DONE;
                end
            end
            sme_pkg::FSM_DIV: begin
                if (div_rsp.done) state_next = sme_pkg::FSM_DONE;
            end
            sme_pkg::FSM_DONE: begin
                if (out_free) state_next = sme_pkg::FSM_IDLE;
            end
            default: state_next = sme_pkg::FSM_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        count_next    = count_reg;
        top_next      = top_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        declared_next = declared_reg;
        stk_we        = 1'b0;
        stk_waddr     = count_m1[SAW-1:0];
        stk_wdata     = top_reg;
        stk_re        = 1'b0;
        stk_raddr     = count_m2[SAW-1:0];
        var_we        = 1'b0;
        var_re        = 1'b0;
        div_req       = '0;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        o_status_next = o_status_reg;
        o_pvalid_next = o_pvalid_reg;
        o_pvalue_next = o_pvalue_reg;
        o_depth_next  = o_depth_reg;

        case (state_reg)
            sme_pkg::FSM_IDLE: begin
                if (s_tvalid) begin
                    cmd_next    = in_cmd;
                    status_next = acc_status;
                    if (acc_status == sme_pkg::STS_OK) begin
                        case (in_cmd)
                            sme_pkg::CMD_PUSH: begin
                                // The old top spills into the RAM below the new one.
                                stk_we     = !stk_empty;
                                top_next   = in_imm;
                                count_next = count_reg + CW'(1);
                            end
                            sme_pkg::CMD_POP: begin
                                stk_re     = 1'b1;
                                count_next = count_m1;
                            end
                            sme_pkg::CMD_SETLOCAL: begin
                                var_we                  = 1'b1;
                                declared_next[var_addr] = 1'b1;
                            end
                            sme_pkg::CMD_GETLOCAL: begin
                                var_re = 1'b1;
                            end
                            sme_pkg::CMD_ADD, sme_pkg::CMD_SUB,
                            sme_pkg::CMD_MUL, sme_pkg::CMD_DIV: begin
                                stk_re     = 1'b1;
                                count_next = count_m1;
                            end
                            default: begin
                                stk_re = 1'b0;
                            end
                        endcase
                    end
                end
            end
            sme_pkg::FSM_LOAD: begin
                if (cmd_reg == sme_pkg::CMD_POP) begin
                    top_next = stk_rdata;
                end else begin
                    stk_we     = !stk_empty;
                    top_next   = var_rdata;
                    count_next = count_reg + CW'(1);
                end
            end
            sme_pkg::FSM_EXEC: begin
                case (cmd_reg)
                    sme_pkg::CMD_ADD: top_next = top_reg + stk_rdata;
                    sme_pkg::CMD_SUB: top_next = top_reg - stk_rdata;
                    sme_pkg::CMD_MUL: top_next = top_reg * stk_rdata;
                    default: begin
                        div_req.start    = 1'b1;
                        div_req.dividend = stk_rdata;
                        div_req.divisor  = top_reg;
                    end
                endcase
            end
            sme_pkg::FSM_DIV: begin
                if (div_rsp.done) top_next = div_rsp.quotient;
            end
            sme_pkg::FSM_DONE: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    o_status_next = status_reg;
                    o_pvalid_next = (status_reg == sme_pkg::STS_OK)
                                    && (cmd_reg == sme_pkg::CMD_PRINT);
                    o_pvalue_next = o_pvalid_next ? top_reg : '0;
                    o_depth_next  = sme_pkg::DEPTH_OUT_W'(count_reg);
                end
            end
            default: begin
                m_valid_next = m_valid_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sme_pkg::FSM_IDLE;
            count_reg    <= '0;
            declared_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            declared_reg <= declared_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        top_reg      <= top_next;
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        o_status_reg <= o_status_next;
        o_pvalid_reg <= o_pvalid_next;
        o_pvalue_reg <= o_pvalue_next;
        o_depth_reg  <= o_depth_next;
    end

    sme_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (SAW),
        .DW    (DW)
    ) u_stack_ram (
        .aclk    (aclk),
        .wr_en   (stk_we),
        .wr_addr (stk_waddr),
        .wr_data (stk_wdata),
        .rd_en   (stk_re),
        .rd_addr (stk_raddr),
        .rd_data (stk_rdata)
    );

    sme_ram #(
        .DEPTH (VAR_SLOTS),
        .AW    (VAW),
        .DW    (DW)
    ) u_var_ram (
        .aclk    (aclk),
        .wr_en   (var_we),
        .wr_addr (var_addr),
        .wr_data (top_reg),
        .rd_en   (var_re),
        .rd_addr (var_addr),
        .rd_data (var_rdata)
    );

    sme_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, o_depth_reg, o_pvalue_reg};
    assign m_tuser  = {o_pvalid_reg, o_status_reg};

endmodule

>>> sv/sme_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the stack machine execute unit, bound to the top level.
module sme_checker #(
    parameter int STACK_DEPTH = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [3:0]  m_tuser
);

    localparam logic [6:0] FULL_DEPTH = 7'(STACK_DEPTH);

    // A stalled result must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A reported print always comes with an ok status, otherwise the value is zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[3] |-> m_tuser[2:0] == sme_pkg::STS_OK)
        else $error("print reported with an error status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[3] |-> m_tdata[31:0] == 32'd0)
        else $error("print value not zero without a print");

    // Overflow is only possible on a full stack, underflow on one of at most one entry.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == sme_pkg::STS_OVERFLOW |-> m_tdata[38:32] == FULL_DEPTH)
        else $error("overflow reported below full depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2:0] == sme_pkg::STS_UNDERFLOW
        |-> m_tdata[38:32] == 7'd0 || m_tdata[38:32] == 7'd1)
        else $error("underflow reported with a deep stack");

endmodule

bind stack_machine_execute_unit sme_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_sme_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

>>> dv/tb_stack_machine_execute_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the stack machine execute unit with its own instruction predictor.
module tb_stack_machine_execute_unit;

    localparam int STACK_DEPTH  = 64;
    localparam int NUM_VARS     = 64;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 60;
    localparam int MAX_REPORTS  = 10;
    localparam int DATA_W       = sme_pkg::DATA_W;
    localparam int VIX_W        = sme_pkg::VIX_W;
    localparam int STATUS_W     = sme_pkg::STATUS_W;
    localparam int DEPTH_OUT_W  = sme_pkg::DEPTH_OUT_W;

    typedef struct packed {
        logic [STATUS_W-1:0]    status;
        logic                   print_valid;
        logic [DATA_W-1:0]      print_value;
        logic [DEPTH_OUT_W-1:0] depth;
    } exec_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [3:0]  m_tuser;

    // Shadow copy of the machine state, updated for every accepted request.
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_count = 0;
    logic [DATA_W-1:0] shadow_vars [NUM_VARS];
    logic              shadow_declared [NUM_VARS];

    exec_result_t pending_results [$];
    int           mismatch_count = 0;
    int           cycle_count = 0;
    bit           quiet_mode = 1'b0;

    stack_machine_execute_unit #(
        .STACK_DEPTH(STACK_DEPTH),
        .NUM_VARS   (NUM_VARS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Signed quotient truncated toward zero, built from magnitudes so that the
    // most negative value over minus one wraps instead of overflowing.
    function automatic logic [DATA_W-1:0] trunc_quotient(input logic [DATA_W-1:0] num,
                                                          input logic [DATA_W-1:0] den);
        logic [DATA_W-1:0] nmag;
        logic [DATA_W-1:0] dmag;
        logic [DATA_W-1:0] q;
        nmag = num[DATA_W-1] ? (~num + 1'b1) : num;
        dmag = den[DATA_W-1] ? (~den + 1'b1) : den;
        q = nmag / dmag;
        return (num[DATA_W-1] != den[DATA_W-1]) ? (~q + 1'b1) : q;
    endfunction

    function automatic exec_result_t exec_instr(input logic [3:0] cmd,
                                                input logic [DATA_W-1:0] imm,
                                                input logic [VIX_W-1:0] vix);
        exec_result_t      r;
        logic [DATA_W-1:0] top;
        logic [DATA_W-1:0] nxt;
        logic [DATA_W-1:0] res;
        r = '0;
        r.status = sme_pkg::STS_OK;
        case (cmd)
            sme_pkg::CMD_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    r.status = sme_pkg::STS_OVERFLOW;
                end else begin
                    shadow_stack[shadow_count] = imm;
                    shadow_count++;
                end
            end
            sme_pkg::CMD_POP: begin
                if (shadow_count == 0) r.status = sme_pkg::STS_UNDERFLOW;
                else shadow_count--;
            end
            sme_pkg::CMD_SETLOCAL: begin
                if (shadow_count == 0) begin
                    r.status = sme_pkg::STS_UNDERFLOW;
                end else if (int'(vix) >= NUM_VARS) begin
                    r.status = sme_pkg::STS_UNDECLARED;
                end else begin
                    shadow_vars[vix] = shadow_stack[shadow_count-1];
                    shadow_declared[vix] = 1'b1;
                end
            end
            sme_pkg::CMD_GETLOCAL: begin
                // An undeclared variable wins over a full stack.
                if (int'(vix) >= NUM_VARS || !shadow_declared[vix]) begin
                    r.status = sme_pkg::STS_UNDECLARED;
                end else if (shadow_count >= STACK_DEPTH) begin
                    r.status = sme_pkg::STS_OVERFLOW;
                end else begin
                    shadow_stack[shadow_count] = shadow_vars[vix];
                    shadow_count++;
                end
            end
            sme_pkg::CMD_ADD, sme_pkg::CMD_SUB, sme_pkg::CMD_MUL, sme_pkg::CMD_DIV: begin
                if (shadow_count < 2) begin
                    r.status = sme_pkg::STS_UNDERFLOW;
                end else begin
                    top = shadow_stack[shadow_count-1];
                    nxt = shadow_stack[shadow_count-2];
                    res = '0;
                    case (cmd)
                        sme_pkg::CMD_ADD: res = top + nxt;
                        sme_pkg::CMD_SUB: res = top - nxt;
                        sme_pkg::CMD_MUL: res = top * nxt;
                        default: begin
                            if (top == '0) r.status = sme_pkg::STS_DIV_ZERO;
                            else res = trunc_quotient(nxt, top);
                        end
                    endcase
                    if (r.status == sme_pkg::STS_OK) begin
                        shadow_stack[shadow_count-2] = res;
                        shadow_count--;
                    end
                end
            end
            sme_pkg::CMD_PRINT: begin
                if (shadow_count == 0) begin
                    r.status = sme_pkg::STS_UNDERFLOW;
                end else begin
                    r.print_valid = 1'b1;
                    r.print_value = shadow_stack[shadow_count-1];
                end
            end
            default: ;
        endcase
        r.depth = shadow_count[DEPTH_OUT_W-1:0];
        return r;
    endfunction

    // Sends one instruction request and records the result it must produce.
    task automatic issue_instr(input logic [3:0] cmd, input logic [DATA_W-1:0] imm,
                               input logic [VIX_W-1:0] vix);
        if (!quiet_mode) begin
            while ($urandom_range(99) < 24) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {2'b00, vix, imm};
        do @(posedge aclk); while (!s_tready);
        pending_results = {pending_results, exec_instr(cmd, imm, vix)};
    endtask

    always @(posedge aclk) begin
        exec_result_t got;
        exec_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status      = m_tuser[2:0];
            got.print_valid = m_tuser[3];
            got.print_value = m_tdata[31:0];
            got.depth       = m_tdata[38:32];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: status=%0d pv=%0b val=%h depth=%0d",
                             got.status, got.print_valid, got.print_value, got.depth);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.print_valid !== want.print_valid ||
                    got.print_value !== want.print_value || got.depth !== want.depth) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"mismatch: exp status=%0d pv=%0b val=%h depth=%0d,",
                                  " got status=%0d pv=%0b val=%h depth=%0d"},
                                 want.status, want.print_valid, want.print_value,
                                 want.depth, got.status, got.print_valid,
                                 got.print_value, got.depth);
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] rand_operand();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0001;
                endcase
            end
            2, 3: return 32'($urandom_range(16)) - 32'd8;
            default: return $urandom;
        endcase
    endfunction

    // Growth mode favors pushes so the stack reaches its limit; drain mode
    // favors consuming operations so it empties again.
    function automatic logic [3:0] pick_command(input int mode);
        int push_share;
        push_share = (mode == 0) ? 65 : (mode == 1) ? 15 : 40;
        if ($urandom_range(99) < push_share)
            return ($urandom_range(3) == 0) ? sme_pkg::CMD_GETLOCAL : sme_pkg::CMD_PUSH;
        case ($urandom_range(7))
            0: return sme_pkg::CMD_POP;
            1: return sme_pkg::CMD_SETLOCAL;
            2: return sme_pkg::CMD_PRINT;
            3: return sme_pkg::CMD_ADD;
            4: return sme_pkg::CMD_SUB;
            5: return sme_pkg::CMD_MUL;
            default: return sme_pkg::CMD_DIV;
        endcase
    endfunction

    task automatic test_basic_ops();
        issue_instr(sme_pkg::CMD_PRINT, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_POP, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_SETLOCAL, 32'h0, 6'd3);
        issue_instr(sme_pkg::CMD_GETLOCAL, 32'h0, 6'd5);
        issue_instr(sme_pkg::CMD_ADD, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'h8000_0000, 6'd0);
        issue_instr(sme_pkg::CMD_DIV, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'hffff_ffff, 6'd0);
        issue_instr(sme_pkg::CMD_DIV, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PRINT, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_DIV, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_POP, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'h7fff_ffff, 6'd63);
        issue_instr(sme_pkg::CMD_ADD, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_SETLOCAL, 32'h0, 6'd63);
        issue_instr(sme_pkg::CMD_GETLOCAL, 32'h0, 6'd63);
        issue_instr(sme_pkg::CMD_SUB, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'hffff_fff9, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'h0000_0002, 6'd0);
        issue_instr(sme_pkg::CMD_DIV, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_MUL, 32'h0, 6'd0);
        issue_instr(4'd15, 32'hffff_ffff, 6'd63);
        issue_instr(4'd9, 32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_PRINT, 32'h0, 6'd0);
    endtask

    task automatic test_stack_limits();
        while (shadow_count < STACK_DEPTH) issue_instr(sme_pkg::CMD_PUSH, $urandom, 6'd0);
        issue_instr(sme_pkg::CMD_PUSH, 32'h1234_5678, 6'd0);
        issue_instr(sme_pkg::CMD_SETLOCAL, 32'h0, 6'd1);
        issue_instr(sme_pkg::CMD_GETLOCAL, 32'h0, 6'd1);
        issue_instr(sme_pkg::CMD_GETLOCAL, 32'h0, 6'd40);
        issue_instr(sme_pkg::CMD_MUL, 32'h0, 6'd0);
        while (shadow_count > 0)
            issue_instr(($urandom_range(4) == 0) ? sme_pkg::CMD_PRINT : sme_pkg::CMD_POP,
                        32'h0, 6'd0);
        issue_instr(sme_pkg::CMD_SETLOCAL, 32'h0, 6'd63);
    endtask

    task automatic test_random(input int n_items);
        int mode;
        logic [3:0] cmd;
        logic [VIX_W-1:0] vix;
        mode = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 50 == 0) mode = $urandom_range(2);
            // A long stretch with both sides always ready.
            quiet_mode = (i >= 600 && i < 900);
            if ($urandom_range(99) < 8) cmd = 4'($urandom_range(15));
            else cmd = pick_command(mode);
            vix = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
            issue_instr(cmd, rand_operand(), vix);
        end
        quiet_mode = 1'b0;
    endtask

    initial begin
        for (int i = 0; i < NUM_VARS; i++) shadow_declared[i] = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_basic_ops();
        test_stack_limits();
        test_random(1590);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> stack_machine_execute_unit.f
sv/sme_pkg.sv
sv/sme_ram.sv
sv/sme_div.sv
sv/stack_machine_execute_unit.sv
sv/sme_checker.sv
dv/tb_stack_machine_execute_unit.sv
